@@ design/canonical_line_editor_macros.svh @@
// Assertion macros shared by the canonical line editor RTL.
`ifndef CANONICAL_LINE_EDITOR_MACROS_SVH
`define CANONICAL_LINE_EDITOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CLE_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("canonical_line_editor: check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CLE_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("canonical_line_editor: check failed");

`else

`define CLE_ASSERT_IMP(name, ante, cons)
`define CLE_ASSERT_NXT(name, ante, cons)

`endif

`endif

@@ design/cle_pkg.sv @@
// Shared types, codes and helpers of the canonical line editor.
package cle_pkg;

	// Default store depth
	localparam int LINE_MAX_DEF = 32;

	// Configuration port widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EOF        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ERASE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WERASE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KILL       = 3'd4;

	// Register reset values
	localparam int          LINE_LIMIT_RST = 20;
	localparam logic [7:0] EOF_RST        = 8'd4;
	localparam logic [7:0] ERASE_RST      = 8'd127;
	localparam logic [7:0] WERASE_RST     = 8'd23;
	localparam logic [7:0] KILL_RST       = 8'd21;

	// Result kinds
	localparam logic [1:0] KIND_ECHO  = 2'd0;
	localparam logic [1:0] KIND_ERASE = 2'd1;
	localparam logic [1:0] KIND_LINE  = 2'd2;
	localparam logic [1:0] KIND_EMPTY = 2'd3;

	// Fixed characters
	localparam logic [7:0] NL_BYTE    = 8'h0a;
	localparam logic [7:0] SPACE_BYTE = 8'h20;
	localparam logic [7:0] TAB_BYTE   = 8'h09;

	// Live configuration, limit already clamped into range
	typedef struct packed {
		logic [5:0] line_limit;
		logic [7:0] eof_code;
		logic [7:0] erase_code;
		logic [7:0] word_erase_code;
		logic [7:0] kill_code;
	} cfg_t;

	// Word separator test for word-erase
	function automatic logic is_blank(input logic [7:0] b);
		return (b == SPACE_BYTE) || (b == TAB_BYTE);
	endfunction

endpackage

@@ design/cle_if.sv @@
// Handshake channels of the canonical line editor: received bytes and results.
interface cle_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface cle_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [5:0] erase_count;
	logic       last;

	modport source (output valid, output kind, output data_byte, output erase_count,
		output last, input ready);
	modport sink (input valid, input kind, input data_byte, input erase_count,
		input last, output ready);
endinterface

@@ design/cle_cfg_regs.sv @@
// Configuration register file of the canonical line editor, limit clamped on write.
module cle_cfg_regs #(
	parameter int LINE_MAX = cle_pkg::LINE_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             we,
	input  logic [cle_pkg::CFG_IDX_W-1:0]    index,
	input  logic [cle_pkg::CFG_DATA_W-1:0]   data,
	output cle_pkg::cfg_t                    cfg
);

	localparam int LIM_RST = (LINE_MAX < cle_pkg::LINE_LIMIT_RST) ?
		LINE_MAX : cle_pkg::LINE_LIMIT_RST;

	cle_pkg::cfg_t cfg_q;
	logic [5:0]    lim_clamped;

	// Clamp written limit into 1..LINE_MAX
	always_comb begin
		if (data[5:0] == 6'd0) begin
			lim_clamped = 6'd1;
		end else if (data[5:0] > 6'(LINE_MAX)) begin
			lim_clamped = 6'(LINE_MAX);
		end else begin
			lim_clamped = data[5:0];
		end
	end

	// Register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_limit      <= 6'(LIM_RST);
			cfg_q.eof_code        <= cle_pkg::EOF_RST;
			cfg_q.erase_code      <= cle_pkg::ERASE_RST;
			cfg_q.word_erase_code <= cle_pkg::WERASE_RST;
			cfg_q.kill_code       <= cle_pkg::KILL_RST;
		end else if (we) begin
			unique case (index)
				cle_pkg::REG_LINE_LIMIT: cfg_q.line_limit      <= lim_clamped;
				cle_pkg::REG_EOF:        cfg_q.eof_code        <= data;
				cle_pkg::REG_ERASE:      cfg_q.erase_code      <= data;
				cle_pkg::REG_WERASE:     cfg_q.word_erase_code <= data;
				cle_pkg::REG_KILL:       cfg_q.kill_code       <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/canonical_line_editor.sv @@
// Top level of the canonical line editor: line store, editing sequencer and result register.
//
//  channel  dir  transaction   payload
//  rx       in   valid&ready   rx_byte
//  res      out  valid&ready   kind, data_byte, erase_count, last
//  cfg      in   cfg_we        cfg_index, cfg_data
//
// The next byte is taken only after an echo, erase, kill or empty-line result is loaded.
// Delivering a line does, per stored byte, a read of the line store, then the load of the
// result register. Word-erase reads and checks each byte it removes, then loads the
// result. Reset clears the fill count, the sequencer, the config registers and the valid
// flag, not the line store. A stalled result register holds the sequencer in place.
module canonical_line_editor #(
	parameter int LINE_MAX = cle_pkg::LINE_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cle_pkg::CFG_DATA_W-1:0] cfg_data,
	cle_rx_if.sink                         rx,
	cle_res_if.source                      res
);

	`include "canonical_line_editor_macros.svh"

	localparam int AW = $clog2(LINE_MAX);
	localparam int CW = $clog2(LINE_MAX + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUT,
		S_WRD,
		S_WCHK,
		S_DRD,
		S_DOUT
	} state_t;

	cle_pkg::cfg_t cfg;

	state_t        state_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] removed_q;
	logic          word_phase_q;
	logic [1:0]    pend_kind_q;
	logic [7:0]    pend_data_q;
	logic [5:0]    pend_cnt_q;
	logic          pend_last_q;
	logic          deliver_after_q;

	logic          out_valid_q;
	logic [1:0]    out_kind_q;
	logic [7:0]    out_data_q;
	logic [5:0]    out_cnt_q;
	logic          out_last_q;

	logic [7:0]    mem [LINE_MAX];
	logic [7:0]    rdata_q;

	logic          in_acc;
	logic          out_free;
	logic          out_load;
	logic          is_eof;
	logic          is_erase;
	logic          is_werase;
	logic          is_kill;
	logic          is_nl;
	logic          fill_zero;
	logic          room;
	logic [CW-1:0] fill_m1;
	logic          reach_lim;
	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic          rd_blank;
	logic          wchk_dec;
	logic          dout_last;

	cle_cfg_regs #(
		.LINE_MAX (LINE_MAX)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// Handshakes
	assign rx.ready = (state_q == S_IDLE);
	assign in_acc   = rx.valid && rx.ready;
	assign out_free = !out_valid_q || res.ready;
	assign out_load = ((state_q == S_PUT) || (state_q == S_DOUT)) && out_free;

	// Byte decode, eof first, then erase, word-erase, kill, newline
	assign is_eof    = (rx.rx_byte == cfg.eof_code);
	assign is_erase  = !is_eof && (rx.rx_byte == cfg.erase_code);
	assign is_werase = !is_eof && !is_erase && (rx.rx_byte == cfg.word_erase_code);
	assign is_kill   = !is_eof && !is_erase && !is_werase && (rx.rx_byte == cfg.kill_code);
	assign is_nl     = !is_eof && !is_erase && !is_werase && !is_kill &&
		(rx.rx_byte == cle_pkg::NL_BYTE);

	assign fill_zero = (fill_q == '0);
	assign room      = (fill_q < CW'(LINE_MAX));
	assign fill_m1   = fill_q - 1'b1;
	assign reach_lim = (7'(fill_q) + 7'd1) >= 7'(cfg.line_limit);

	// Line store accesses
	assign mem_we    = in_acc && room && !is_eof && !is_erase && !is_werase && !is_kill;
	assign mem_re    = (state_q == S_DRD) || ((state_q == S_WRD) && !fill_zero);
	assign mem_raddr = (state_q == S_DRD) ? rd_idx_q[AW-1:0] : fill_m1[AW-1:0];

	assign rd_blank  = cle_pkg::is_blank(rdata_q);
	assign wchk_dec  = word_phase_q ? !rd_blank : rd_blank;
	assign dout_last = (7'(rd_idx_q) + 7'd1) == 7'(fill_q);

	// Store write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[fill_q[AW-1:0]] <= rx.rx_byte;
		end
	end

	// Store read port, registered
	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// Editing sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			fill_q          <= '0;
			rd_idx_q        <= '0;
			removed_q       <= '0;
			word_phase_q    <= 1'b0;
			deliver_after_q <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (out_valid_q && res.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						rd_idx_q        <= '0;
						deliver_after_q <= 1'b0;
						pend_data_q     <= 8'd0;
						pend_cnt_q      <= 6'd0;
						pend_last_q     <= 1'b0;
						if (is_eof) begin
							if (fill_zero) begin
								pend_kind_q <= cle_pkg::KIND_EMPTY;
								pend_last_q <= 1'b1;
								state_q     <= S_PUT;
							end else begin
								state_q <= S_DRD;
							end
						end else if (is_erase) begin
							if (!fill_zero) begin
								fill_q      <= fill_m1;
								pend_kind_q <= cle_pkg::KIND_ERASE;
								pend_cnt_q  <= 6'd1;
								state_q     <= S_PUT;
							end
						end else if (is_werase) begin
							if (!fill_zero) begin
								removed_q    <= '0;
								word_phase_q <= 1'b0;
								state_q      <= S_WRD;
							end
						end else if (is_kill) begin
							if (!fill_zero) begin
								fill_q      <= '0;
								pend_kind_q <= cle_pkg::KIND_ERASE;
								pend_cnt_q  <= 6'(fill_q);
								state_q     <= S_PUT;
							end
						end else if (is_nl) begin
							if (room) begin
								fill_q <= fill_q + 1'b1;
							end
							state_q <= S_DRD;
						end else if (!room) begin
							// full store: byte dropped, line goes out
							state_q <= S_DRD;
						end else begin
							fill_q          <= fill_q + 1'b1;
							pend_kind_q     <= cle_pkg::KIND_ECHO;
							pend_data_q     <= rx.rx_byte;
							deliver_after_q <= reach_lim;
							state_q         <= S_PUT;
						end
					end
				end
				S_PUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= pend_kind_q;
						out_data_q  <= pend_data_q;
						out_cnt_q   <= pend_cnt_q;
						out_last_q  <= pend_last_q;
						state_q     <= deliver_after_q ? S_DRD : S_IDLE;
					end
				end
				S_WRD: begin
					if (fill_zero) begin
						pend_kind_q     <= cle_pkg::KIND_ERASE;
						pend_data_q     <= 8'd0;
						pend_cnt_q      <= 6'(removed_q);
						pend_last_q     <= 1'b0;
						deliver_after_q <= 1'b0;
						state_q         <= S_PUT;
					end else begin
						state_q <= S_WCHK;
					end
				end
				S_WCHK: begin
					if (wchk_dec) begin
						fill_q    <= fill_m1;
						removed_q <= removed_q + 1'b1;
						state_q   <= S_WRD;
					end else if (!word_phase_q) begin
						// first non-blank: same entry is rechecked as part of the word
						word_phase_q <= 1'b1;
					end else begin
						pend_kind_q     <= cle_pkg::KIND_ERASE;
						pend_data_q     <= 8'd0;
						pend_cnt_q      <= 6'(removed_q);
						pend_last_q     <= 1'b0;
						deliver_after_q <= 1'b0;
						state_q         <= S_PUT;
					end
				end
				S_DRD: begin
					state_q <= S_DOUT;
				end
				S_DOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= cle_pkg::KIND_LINE;
						out_data_q  <= rdata_q;
						out_cnt_q   <= 6'd0;
						out_last_q  <= dout_last;
						if (dout_last) begin
							fill_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
							state_q  <= S_DRD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid       = out_valid_q;
	assign res.kind        = out_kind_q;
	assign res.data_byte   = out_data_q;
	assign res.erase_count = out_cnt_q;
	assign res.last        = out_last_q;

	// Checks
	`CLE_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= CW'(LINE_MAX))
	`CLE_ASSERT_NXT(a_last_empties, (state_q == S_DOUT) && out_free && dout_last, (fill_q == '0) && (state_q == S_IDLE))
	`CLE_ASSERT_NXT(a_word_step, (state_q == S_WCHK) && wchk_dec, fill_q == ($past(fill_q) - 1'b1))

endmodule
